[rtl/core/timestamped_pose_ring_interpolator_assert.svh]
// Assertion shorthands for the pose ring checker.
`ifndef TIMESTAMPED_POSE_RING_INTERPOLATOR_ASSERT_SVH
`define TIMESTAMPED_POSE_RING_INTERPOLATOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TPRI_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TPRI_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tpri_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpri_pkg;

	localparam int RING_DEPTH_DEF = 16;

	localparam logic [2:0] ST_EMPTY   = 3'd0;
	localparam logic [2:0] ST_STARVED = 3'd1;
	localparam logic [2:0] ST_DRY     = 3'd2;
	localparam logic [2:0] ST_BEHIND  = 3'd3;
	localparam logic [2:0] ST_INTERP  = 3'd4;
	localparam logic [2:0] ST_STORED  = 3'd5;
	localparam logic [2:0] ST_STALE   = 3'd6;

	localparam logic [2:0] FLD_X     = 3'd0;
	localparam logic [2:0] FLD_Y     = 3'd1;
	localparam logic [2:0] FLD_Z     = 3'd2;
	localparam logic [2:0] FLD_YAW   = 3'd3;
	localparam logic [2:0] FLD_PITCH = 3'd4;
	localparam logic [2:0] FLD_BODY  = 3'd5;

	// compare-subtract unit width: covers the wrap operand
	localparam int CS_W = 35;
	localparam logic [CS_W-1:0] DEG360    = 35'd23592960;
	localparam logic [CS_W-1:0] DEG180    = 35'd11796480;
	// 256 turns: lifts any 33-bit difference above zero
	localparam logic [CS_W-1:0] WRAP_BIAS = 35'd6039797760;
	localparam logic [3:0] WRAP_LAST = 4'd8;
	localparam logic [3:0] DIV_LAST  = 4'd15;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t yaw;
		coord_t pitch;
		coord_t yaw_body;
	} pose_t;

	typedef struct packed {
		logic            ge;
		logic [CS_W-1:0] diff;
	} cs_res_t;

	function automatic coord_t get_field(pose_t p, logic [2:0] f);
		case (f)
			FLD_X:     return p.x;
			FLD_Y:     return p.y;
			FLD_Z:     return p.z;
			FLD_YAW:   return p.yaw;
			FLD_PITCH: return p.pitch;
			FLD_BODY:  return p.yaw_body;
			default:   return '0;
		endcase
	endfunction

	function automatic pose_t set_field(pose_t p, logic [2:0] f, coord_t v);
		pose_t r;
		r = p;
		case (f)
			FLD_X:     r.x = v;
			FLD_Y:     r.y = v;
			FLD_Z:     r.z = v;
			FLD_YAW:   r.yaw = v;
			FLD_PITCH: r.pitch = v;
			FLD_BODY:  r.yaw_body = v;
			default:   r = p;
		endcase
		return r;
	endfunction

	function automatic logic is_angle(logic [2:0] f);
		return (f == FLD_YAW) || (f == FLD_BODY);
	endfunction

endpackage

`default_nettype wire

[rtl/core/tpri_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tpri_req_if import tpri_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] stamp_tick;
	coord_t      in_pos_x;
	coord_t      in_pos_y;
	coord_t      in_pos_z;
	coord_t      in_yaw;
	coord_t      in_pitch;
	coord_t      in_body_yaw;
	logic [47:0] sample_cursor;

	modport source (
		output valid, command, stamp_tick, in_pos_x, in_pos_y, in_pos_z,
		output in_yaw, in_pitch, in_body_yaw, sample_cursor,
		input  ready
	);
	modport sink (
		input  valid, command, stamp_tick, in_pos_x, in_pos_y, in_pos_z,
		input  in_yaw, in_pitch, in_body_yaw, sample_cursor,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/tpri_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tpri_res_if import tpri_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] status;
	coord_t     out_pos_x;
	coord_t     out_pos_y;
	coord_t     out_pos_z;
	coord_t     out_yaw;
	coord_t     out_pitch;
	coord_t     out_body_yaw;

	modport source (
		output valid, status, out_pos_x, out_pos_y, out_pos_z,
		output out_yaw, out_pitch, out_body_yaw,
		input  ready
	);
	modport sink (
		input  valid, status, out_pos_x, out_pos_y, out_pos_z,
		input  out_yaw, out_pitch, out_body_yaw,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/timestamped_pose_ring_interpolator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pose ring with timed sampling. A push request (command 0) stores the pose when its stamp is
// newer than the newest held stamp and answers stored, or answers stale and drops it; either
// answer is registered and shown in the cycle after the request. A sample request (command 1)
// answers empty in the same way; it answers starved, dry or behind through the emit state, and
// interpolated after the ring walk, which reads stamps one at a time from the oldest entry to
// find the bracketing pair, the 16-step restoring divider for the fraction, and the field loop
// over all six fields; the short-way wrap of each angle field runs nine steps on the same
// compare-subtract unit that the divider uses. One multiplier serves all six lerps. The ring is
// two memories, stamps and packed poses, each with one write port and a registered read; no
// clearing pass is needed since only written entries are ever read. New requests are taken only
// while the sequencer is idle and the result register is free or being drained.
module timestamped_pose_ring_interpolator import tpri_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	tpri_req_if.sink   req,
	tpri_res_if.source res
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);
	localparam logic [CW-1:0] TWO  = CW'(2);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_OLD   = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;
	localparam logic [3:0] S_WALKW = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_LDA   = 4'd5;
	localparam logic [3:0] S_LDB   = 4'd6;
	localparam logic [3:0] S_LDC   = 4'd7;
	localparam logic [3:0] S_DIFF  = 4'd8;
	localparam logic [3:0] S_WRAP  = 4'd9;
	localparam logic [3:0] S_WFIN  = 4'd10;
	localparam logic [3:0] S_MUL   = 4'd11;
	localparam logic [3:0] S_ADD   = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;

	function automatic logic [AW-1:0] ring_inc(logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	// ring memories
	logic [31:0] stamp_mem [RING_DEPTH];
	pose_t       pose_mem  [RING_DEPTH];
	logic [31:0] stamp_rd_q;
	pose_t       pose_rd_q;
	logic [AW-1:0] s_addr, p_addr;

	// control and datapath registers
	logic [3:0]        state_q;
	logic [AW-1:0]     wp_q, lo_q, hi_q, slot_q;
	logic [CW-1:0]     held_q;
	logic [31:0]       newest_stamp_q, lo_stamp_q, hi_stamp_q;
	logic [47:0]       cursor_q;
	logic [31:0]       rem_q;
	logic [15:0]       numlo_q, frac_q;
	logic [3:0]        step_q;
	logic [2:0]        fld_q;
	pose_t             a_pose_q, b_pose_q, result_q;
	logic [CS_W-1:0]   v_q;
	logic signed [33:0] d_q;
	logic signed [50:0] prod_q;
	logic [2:0]        status_q;

	// result register
	logic        ov_q;
	logic [2:0]  out_status_q;
	pose_t       out_pose_q;

	logic accept, is_push, stale, out_free;
	logic [AW-1:0] newest, oldest;
	logic [31:0] span;
	logic [47:0] num;
	logic [CS_W-1:0] cs_a, cs_b;
	cs_res_t cs_res;
	coord_t fa, fb;
	logic signed [33:0] dd;
	logic signed [35:0] sum;
	coord_t fres;
	pose_t  in_pose;

	assign out_free = !ov_q || res.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept = req.valid && req.ready;
	assign is_push = !req.command;
	assign newest = (wp_q == '0) ? LAST : wp_q - 1'b1;
	// until the ring wraps, the oldest pose sits in slot zero
	assign oldest = (held_q == FULL) ? wp_q : '0;
	assign stale = (held_q != '0) && (req.stamp_tick <= newest_stamp_q);
	assign span = hi_stamp_q - lo_stamp_q;
	assign num = cursor_q - {lo_stamp_q, 16'h0000};

	assign in_pose.x        = req.in_pos_x;
	assign in_pose.y        = req.in_pos_y;
	assign in_pose.z        = req.in_pos_z;
	assign in_pose.yaw      = req.in_yaw;
	assign in_pose.pitch    = req.in_pitch;
	assign in_pose.yaw_body = req.in_body_yaw;

	// steer the memory read ports
	always_comb begin
		s_addr = hi_q;
		p_addr = slot_q;
		case (state_q)
			S_IDLE: begin
				s_addr = oldest;
				p_addr = newest;
			end
			S_OLD:   p_addr = lo_q;
			S_LDA:   p_addr = lo_q;
			S_LDB:   p_addr = hi_q;
			default: p_addr = slot_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && is_push && !stale) begin
			stamp_mem[wp_q] <= req.stamp_tick;
			pose_mem[wp_q]  <= in_pose;
		end
		stamp_rd_q <= stamp_mem[s_addr];
		pose_rd_q  <= pose_mem[p_addr];
	end

	// feed the shared unit: divider steps, then wrap steps
	always_comb begin
		cs_a = '0;
		cs_b = '0;
		case (state_q)
			S_DIV: begin
				cs_a = {2'b00, rem_q, numlo_q[15]};
				cs_b = {3'b000, span};
			end
			S_WRAP: begin
				cs_a = v_q;
				cs_b = WRAP_BIAS >> step_q;
			end
			default: begin
				cs_a = '0;
				cs_b = '0;
			end
		endcase
	end

	tpri_cmpsub u_cmpsub (
		.a   (cs_a),
		.b   (cs_b),
		.res (cs_res)
	);

	// field arithmetic
	assign fa = get_field(a_pose_q, fld_q);
	assign fb = get_field(b_pose_q, fld_q);
	assign dd = {fb[31], fb[31], fb} - {fa[31], fa[31], fa};
	assign sum = {{4{fa[31]}}, fa} + {prod_q[50], prod_q[50:16]};

	always_comb begin
		fres = sum[31:0];
		if (is_angle(fld_q) && (sum[35:31] != {5{sum[35]}}))
			fres = sum[35] ? 32'sh80000000 : 32'sh7fffffff;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			held_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (res.ready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lo_q     <= oldest;
						hi_q     <= ring_inc(oldest);
						slot_q   <= newest;
						cursor_q <= req.sample_cursor;
						if (is_push) begin
							// answer at once; zeros in every pose field
							ov_q         <= 1'b1;
							out_pose_q   <= '0;
							out_status_q <= stale ? ST_STALE : ST_STORED;
							if (!stale) begin
								newest_stamp_q <= req.stamp_tick;
								wp_q <= ring_inc(wp_q);
								if (held_q != FULL)
									held_q <= held_q + 1'b1;
							end
						end else if (held_q == '0) begin
							ov_q         <= 1'b1;
							out_pose_q   <= '0;
							out_status_q <= ST_EMPTY;
						end else if (held_q < TWO) begin
							status_q <= ST_STARVED;
							state_q  <= S_EMIT;
						end else if (req.sample_cursor >= {newest_stamp_q, 16'h0000}) begin
							status_q <= ST_DRY;
							state_q  <= S_EMIT;
						end else begin
							state_q <= S_OLD;
						end
					end
				end
				S_OLD: begin
					if (cursor_q < {stamp_rd_q, 16'h0000}) begin
						status_q <= ST_BEHIND;
						slot_q   <= lo_q;
						state_q  <= S_EMIT;
					end else begin
						lo_stamp_q <= stamp_rd_q;
						state_q    <= S_WALK;
					end
				end
				S_WALK: begin
					if (cursor_q < {stamp_rd_q, 16'h0000}) begin
						// pair found: load the dividend
						hi_stamp_q <= stamp_rd_q;
						rem_q      <= num[47:16];
						numlo_q    <= num[15:0];
						step_q     <= '0;
						state_q    <= S_DIV;
					end else begin
						// advance the pair by one slot
						lo_stamp_q <= stamp_rd_q;
						lo_q       <= hi_q;
						hi_q       <= ring_inc(hi_q);
						state_q    <= S_WALKW;
					end
				end
				S_WALKW: begin
					// wait for the next stamp read
					state_q <= S_WALK;
				end
				S_DIV: begin
					rem_q   <= cs_res.ge ? cs_res.diff[31:0] : cs_a[31:0];
					numlo_q <= {numlo_q[14:0], 1'b0};
					frac_q  <= {frac_q[14:0], cs_res.ge};
					step_q  <= step_q + 1'b1;
					if (step_q == DIV_LAST)
						state_q <= S_LDA;
				end
				S_LDA: begin
					if (span == '0)
						frac_q <= '0;
					state_q <= S_LDB;
				end
				S_LDB: begin
					a_pose_q <= pose_rd_q;
					state_q  <= S_LDC;
				end
				S_LDC: begin
					b_pose_q <= pose_rd_q;
					fld_q    <= FLD_X;
					state_q  <= S_DIFF;
				end
				S_DIFF: begin
					if (is_angle(fld_q)) begin
						v_q     <= {dd[33], dd} + WRAP_BIAS;
						step_q  <= '0;
						state_q <= S_WRAP;
					end else begin
						d_q     <= dd;
						state_q <= S_MUL;
					end
				end
				S_WRAP: begin
					// drop one multiple of 360 degrees per step, largest first
					if (cs_res.ge)
						v_q <= cs_res.diff;
					step_q <= step_q + 1'b1;
					if (step_q == WRAP_LAST)
						state_q <= S_WFIN;
				end
				S_WFIN: begin
					d_q     <= (v_q >= DEG180) ? 34'(v_q - DEG360) : v_q[33:0];
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= d_q * $signed({1'b0, frac_q});
					state_q <= S_ADD;
				end
				S_ADD: begin
					result_q <= set_field(result_q, fld_q, fres);
					if (fld_q == FLD_BODY) begin
						status_q <= ST_INTERP;
						state_q  <= S_EMIT;
					end else begin
						fld_q   <= fld_q + 1'b1;
						state_q <= S_DIFF;
					end
				end
				S_EMIT: begin
					// hold until the result register frees up
					if (out_free) begin
						ov_q         <= 1'b1;
						out_status_q <= status_q;
						out_pose_q   <= (status_q == ST_INTERP) ? result_q : pose_rd_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid        = ov_q;
	assign res.status       = out_status_q;
	assign res.out_pos_x    = out_pose_q.x;
	assign res.out_pos_y    = out_pose_q.y;
	assign res.out_pos_z    = out_pose_q.z;
	assign res.out_yaw      = out_pose_q.yaw;
	assign res.out_pitch    = out_pose_q.pitch;
	assign res.out_body_yaw = out_pose_q.yaw_body;

endmodule

`default_nettype wire

[rtl/core/tpri_cmpsub.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shared compare-and-subtract step for the divider and the angle wrap.
module tpri_cmpsub import tpri_pkg::*; (
	input  logic [CS_W-1:0] a,
	input  logic [CS_W-1:0] b,
	output cs_res_t         res
);
	assign res.ge   = (a >= b);
	assign res.diff = a - b;
endmodule

`default_nettype wire

[rtl/core/tpri_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "timestamped_pose_ring_interpolator_assert.svh"

module tpri_checker import tpri_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       req_command,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_status
);
	`TPRI_ASSERT_RST(a_quiet_in_reset, !arst_n |-> !res_valid, "result shown during reset")
	`TPRI_ASSERT_CLK(a_res_hold, (res_valid && !res_ready) |=> res_valid, "result dropped")
	`TPRI_ASSERT_CLK(a_push_answer, (req_valid && req_ready && !req_command) |=> (res_valid && (res_status == ST_STORED || res_status == ST_STALE)), "push not answered next cycle")
	`TPRI_ASSERT_CLK(a_sample_answer, (req_valid && req_ready && req_command) |=> !(res_valid && (res_status == ST_STORED || res_status == ST_STALE)), "sample answered as push")
endmodule

bind timestamped_pose_ring_interpolator tpri_checker u_tpri_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_command (req.command),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_status  (res.status)
);

`default_nettype wire
